FILE: src/rpn_stack_evaluator_defines.svh
// -----------------------------------------------------------------------------
// rpn_stack_evaluator_defines: assertion macros for the RPN evaluator
// Shared concurrent-assertion shorthands, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// -----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_DEFINES_SVH
`define RPN_STACK_EVALUATOR_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define RPN_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define RPN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rpn_pkg.sv
// -----------------------------------------------------------------------------
// rpn_pkg: shared types and constants of the RPN stack evaluator
// Token and status codes, stack sizing, and the command/status bundles
// between the controller and the datapath.
// -----------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// token codes
	localparam logic [2:0] MODE_PUSH  = 3'd0;
	localparam logic [2:0] MODE_ADD   = 3'd1;
	localparam logic [2:0] MODE_SUB   = 3'd2;
	localparam logic [2:0] MODE_MUL   = 3'd3;
	localparam logic [2:0] MODE_DIV   = 3'd4;
	localparam logic [2:0] MODE_OTHER = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_LEFTOVER  = 3'd2;
	localparam logic [2:0] ST_EMPTY     = 3'd3;
	localparam logic [2:0] ST_DIVZERO   = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the input token
		logic push;       // push operand or flag overflow
		logic set_under;  // flag underflow
		logic rd_ops;     // read the two top entries
		logic pop2;       // drop the two operands
		logic eval;       // register add/sub/mul result
		logic set_dz;     // flag divide by zero
		logic div_start;  // launch the divider
		logic div_take;   // register the quotient
		logic wb;         // push the registered result
		logic fin_rd;     // read the bottom entry
		logic fin_out;    // load the result register, clear the expression
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err;        // sticky error pending
		logic is_push;
		logic is_arith;   // add, subtract or multiply
		logic is_div;
		logic cnt_lt2;
		logic b_zero;
		logic last;
		logic div_done;
		logic out_free;   // result register can take a new result
	} sts_t;

endpackage

FILE: src/rpn_div.sv
// -----------------------------------------------------------------------------
// rpn_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// negated when the operand signs differ. Truncates toward zero.
// -----------------------------------------------------------------------------
module rpn_div
	import rpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int ITER_W = $clog2(DATA_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] iter_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [DATA_W:0]   trial;

	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(DATA_W);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

FILE: src/rpn_dpath.sv
// -----------------------------------------------------------------------------
// rpn_dpath: datapath of the RPN stack evaluator
// Token register, stack memory with count and sticky error, ALU, divider
// and the result register.
// -----------------------------------------------------------------------------
`include "rpn_stack_evaluator_defines.svh"

module rpn_dpath
	import rpn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [2:0]        in_mode,
	input  logic [DATA_W-1:0] in_operand,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] out_value,
	output logic [2:0]        out_status
);

	logic [DATA_W-1:0] mem [STACK_DEPTH];

	logic [2:0]        mode_q;
	logic [DATA_W-1:0] operand_q;
	logic              last_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [2:0]        err_q;
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;
	logic [DATA_W-1:0] res_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [2:0]        out_status_q;

	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic              div_done;
	logic [DATA_W-1:0] div_quo;
	logic              is_push;
	logic              is_arith;
	logic              is_div;

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign cnt_m2 = cnt_q - CNT_W'(2);

	always_comb begin
		is_push  = 1'b0;
		is_arith = 1'b0;
		is_div   = 1'b0;
		unique case (mode_q) inside
			MODE_PUSH:                   is_push  = 1'b1;
			MODE_ADD, MODE_SUB, MODE_MUL: is_arith = 1'b1;
			MODE_DIV:                    is_div   = 1'b1;
			default:                     ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q    <= in_mode;
			operand_q <= in_operand;
			last_q    <= in_last;
		end
	end

	// stack memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (cmd.push && (cnt_q != CNT_W'(STACK_DEPTH)))
			mem[cnt_q[ADDR_W-1:0]] <= operand_q;
		else if (cmd.wb)
			mem[cnt_q[ADDR_W-1:0]] <= res_q;
		if (cmd.rd_ops) begin
			rd_a_q <= mem[cnt_m2[ADDR_W-1:0]];
			rd_b_q <= mem[cnt_m1[ADDR_W-1:0]];
		end else if (cmd.fin_rd) begin
			rd_a_q <= mem[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= ST_OK;
		end else begin
			if (cmd.fin_out) begin
				cnt_q <= '0;
				err_q <= ST_OK;
			end else begin
				if (cmd.push) begin
					if (cnt_q == CNT_W'(STACK_DEPTH))
						err_q <= ST_OVERFLOW;
					else
						cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cmd.set_under)
					err_q <= ST_UNDERFLOW;
				if (cmd.set_dz)
					err_q <= ST_DIVZERO;
				if (cmd.pop2)
					cnt_q <= cnt_m2;
				if (cmd.wb)
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// one operation per token: wrap-around add, subtract, low half of product
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			case (mode_q)
				MODE_ADD: res_q <= rd_a_q + rd_b_q;
				MODE_SUB: res_q <= rd_a_q - rd_b_q;
				default:  res_q <= rd_a_q * rd_b_q;
			endcase
		end else if (cmd.div_take) begin
			res_q <= div_quo;
		end
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_a_q),
		.divisor  (rd_b_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fin_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_out) begin
			if (err_q != ST_OK) begin
				out_status_q <= err_q;
				out_value_q  <= '0;
			end else if (cnt_q > CNT_W'(1)) begin
				out_status_q <= ST_LEFTOVER;
				out_value_q  <= '0;
			end else if (cnt_q == '0) begin
				out_status_q <= ST_EMPTY;
				out_value_q  <= '0;
			end else begin
				out_status_q <= ST_OK;
				out_value_q  <= rd_a_q;
			end
		end
	end

	assign sts.err      = (err_q != ST_OK);
	assign sts.is_push  = is_push;
	assign sts.is_arith = is_arith;
	assign sts.is_div   = is_div;
	assign sts.cnt_lt2  = (cnt_q < CNT_W'(2));
	assign sts.b_zero   = (rd_b_q == '0);
	assign sts.last     = last_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_status = out_status_q;

	`RPN_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH),
		"stack count beyond depth")
	`RPN_ASSERT_NEXT(a_fin_clears, clk, arst_n, cmd.fin_out, (cnt_q == '0) && (err_q == ST_OK),
		"expression state not cleared after result")
	`RPN_ASSERT_IMPL(a_wb_no_err, clk, arst_n, cmd.wb, err_q == ST_OK,
		"result written back under a pending error")
	`RPN_ASSERT_IMPL(a_pop_has_ops, clk, arst_n, cmd.pop2, cnt_q >= CNT_W'(2),
		"operands popped from a short stack")

endmodule

FILE: src/rpn_ctrl.sv
// -----------------------------------------------------------------------------
// rpn_ctrl: sequencer of the RPN stack evaluator
// Walks one token through check, operand read, evaluate, divide wait and
// write-back, then finishes the expression on its last token.
// -----------------------------------------------------------------------------
module rpn_ctrl
	import rpn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_OPER,
		S_DIVW,
		S_WB,
		S_FIN_RD,
		S_FIN_OUT
	} state_t;

	state_t state_q;
	state_t state_nx;
	state_t done_nx;

	assign done_nx  = sts.last ? S_FIN_RD : S_IDLE;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.err) begin
					state_nx = done_nx;
				end else if (sts.is_push) begin
					cmd.push = 1'b1;
					state_nx = done_nx;
				end else if (sts.cnt_lt2) begin
					cmd.set_under = 1'b1;
					state_nx      = done_nx;
				end else begin
					cmd.rd_ops = 1'b1;
					state_nx   = S_OPER;
				end
			end
			S_OPER: begin
				cmd.pop2 = 1'b1;
				if (sts.is_arith) begin
					cmd.eval = 1'b1;
					state_nx = S_WB;
				end else if (sts.is_div) begin
					if (sts.b_zero) begin
						cmd.set_dz = 1'b1;
						state_nx   = done_nx;
					end else begin
						cmd.div_start = 1'b1;
						state_nx      = S_DIVW;
					end
				end else begin
					state_nx = done_nx;
				end
			end
			S_DIVW: begin
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_nx     = S_WB;
				end
			end
			S_WB: begin
				cmd.wb   = 1'b1;
				state_nx = done_nx;
			end
			S_FIN_RD: begin
				cmd.fin_rd = 1'b1;
				state_nx   = S_FIN_OUT;
			end
			S_FIN_OUT: begin
				if (sts.out_free) begin
					cmd.fin_out = 1'b1;
					state_nx    = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

endmodule

FILE: src/rpn_stack_evaluator.sv
// -----------------------------------------------------------------------------
// rpn_stack_evaluator: reverse Polish token evaluator with a bounded stack
//
//   channel   dir  tdata                         tuser         tlast
//   s_axis    in   [2:0] mode, [34:3] operand    -             last token
//   m_axis    out  [31:0] value                  [2:0] status  -
//
// A push, a rejected or a skipped token ends in the check step; add, subtract
// and multiply go on through operand read, evaluate and write-back; divide
// waits for the divider (32 quotient bits, one bit per cycle) before write-back.
// The last token then reads the stack bottom and loads the result register.
// Reset (arst_n low) empties the stack and clears the sticky error; stack
// memory contents are left as they are, no clearing pass is run.
// A result waits in the output register while the next tokens are taken; the
// block stalls only when a second result is ready before the first is taken.
// -----------------------------------------------------------------------------
module rpn_stack_evaluator
	import rpn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input transactions: one token each
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [2:0] mode, [34:3] operand, [39:35] zero
	input  logic        s_tlast,   // last token of the expression
	// output transactions: one result per expression
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [7:0]  m_tuser    // [2:0] status, [7:3] zero
);

	cmd_t        cmd;
	sts_t        sts;
	logic [2:0]  out_status;

	// sequencer: hands out one step command per cycle unless it is waiting
	rpn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: stack, ALU, divider and result register
	rpn_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (s_tdata[2:0]),
		.in_operand (s_tdata[34:3]),
		.in_last    (s_tlast),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_status (out_status)
	);

	// pad the status up to a whole byte
	assign m_tuser = {5'b0, out_status};

endmodule

FILE: dv/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top: self-checking testbench for the RPN stack evaluator
// Drives token streams: a short directed set, then random expressions that are
// mostly well formed, with broken ones, noise and full-depth stack runs mixed
// in. A scoreboard class tracks its own stack per token and checks each result
// against the oldest pending one. Both stream sides idle at random, and the
// result side holds off once for a long stretch so the block fills up.
// -----------------------------------------------------------------------------
module tb_top
	import rpn_pkg::*;
();

	localparam int CLK_PERIOD        = 12;
	localparam int RESET_CYCLES      = 11;
	localparam int ITEM_TARGET       = 750;
	localparam int HOLD_AFTER_TOKENS = 200;
	localparam int LONG_HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES      = 80;
	localparam int TIMEOUT_CYCLES    = 300000;
	localparam int REPORT_LIMIT      = 10;

	// codes outside the package set; the block treats them as "other operator"
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] operand;
	} token_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [2:0]        status;
	} expr_result_t;

	// Tracks the evaluator stack token by token and holds the results still owed.
	class expr_result_tracker;
		logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
		int unsigned       depth;
		logic [2:0]        err;
		expr_result_t      owed_results [$];
		int unsigned       failures;
		int unsigned       result_idx;

		function new();
			depth      = 0;
			err        = ST_OK;
			failures   = 0;
			result_idx = 0;
		endfunction

		function int unsigned pending_count();
			return owed_results.size();
		endfunction

		// Signed divide truncated toward zero, built on magnitudes so that the
		// most negative value over minus one wraps instead of trapping.
		function logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
			logic [DATA_W-1:0] mag_a;
			logic [DATA_W-1:0] mag_b;
			logic [DATA_W-1:0] q;
			mag_a = a[DATA_W-1] ? -a : a;
			mag_b = b[DATA_W-1] ? -b : b;
			q     = mag_a / mag_b;
			return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
		endfunction

		function void take_token(logic [2:0] mode, logic [31:0] operand, bit last);
			logic [DATA_W-1:0] a;
			logic [DATA_W-1:0] b;
			expr_result_t      res;
			if (err == ST_OK) begin
				if (mode == MODE_PUSH) begin
					if (depth >= STACK_DEPTH) begin
						err = ST_OVERFLOW;
					end else begin
						stack_mem[depth] = operand;
						depth++;
					end
				end else if (depth < 2) begin
					err = ST_UNDERFLOW;
				end else begin
					b     = stack_mem[depth-1];
					a     = stack_mem[depth-2];
					depth = depth - 2;
					case (mode)
						MODE_ADD: begin
							stack_mem[depth] = a + b;
							depth++;
						end
						MODE_SUB: begin
							stack_mem[depth] = a - b;
							depth++;
						end
						MODE_MUL: begin
							stack_mem[depth] = a * b;
							depth++;
						end
						MODE_DIV: begin
							if (b == '0) begin
								err = ST_DIVZERO;
							end else begin
								stack_mem[depth] = quotient(a, b);
								depth++;
							end
						end
						default: ; // other operator: drop both operands
					endcase
				end
			end
			if (!last) return;
			res.value  = '0;
			res.status = err;
			if (err == ST_OK) begin
				if (depth > 1) res.status = ST_LEFTOVER;
				else if (depth == 0) res.status = ST_EMPTY;
				else res.value = stack_mem[0];
			end
			owed_results.insert(owed_results.size(), res);
			depth = 0;
			err   = ST_OK;
		endfunction

		function void match_result(logic [DATA_W-1:0] value, logic [2:0] status);
			expr_result_t owed;
			if (owed_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result %0d: value %h status %0d",
						result_idx, value, status);
			end else begin
				owed = owed_results.pop_front();
				if (value !== owed.value || status !== owed.status) begin
					failures++;
					if (failures <= REPORT_LIMIT)
						$display({"result %0d mismatch: expected value %h status %0d,",
							" got value %h status %0d"},
							result_idx, owed.value, owed.status, value, status);
				end
			end
			result_idx++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;    // [2:0] mode, [34:3] operand, [39:35] zero
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [31:0] value
	logic [7:0]  m_tuser;    // [2:0] status, [7:3] zero

	expr_result_tracker tracker;
	token_t             expr_tokens [$];
	int unsigned        tokens_sent;
	int unsigned        burst_left;
	bit                 long_hold_done;

	rpn_stack_evaluator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD/2) clk = ~clk;

	// Bias operands toward the corners of the signed range.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return WORD_MIN;
			4: return WORD_MAX;
			5: return 32'($urandom_range(0, 32)) - 32'd16;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [2:0] pick_operator();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 20) return MODE_ADD;
		if (roll < 40) return MODE_SUB;
		if (roll < 60) return MODE_MUL;
		if (roll < 85) return MODE_DIV;
		if (roll < 92) return MODE_OTHER;
		if (roll < 96) return MODE_SPARE6;
		return MODE_SPARE7;
	endfunction

	function automatic void add_token(logic [2:0] mode, logic [31:0] operand);
		token_t tok;
		tok.mode    = mode;
		tok.operand = operand;
		expr_tokens.insert(expr_tokens.size(), tok);
	endfunction

	// Offer one token and hold it until the block takes it. Open a gap of idle
	// cycles most times that the current burst runs out.
	task automatic send_token(input logic [2:0] mode, input logic [31:0] operand, input bit last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, operand, mode};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_token(mode, operand, last);
		tokens_sent++;
		burst_left--;
	endtask

	task automatic run_expression();
		int unsigned n;
		n = expr_tokens.size();
		for (int unsigned i = 0; i < n; i++)
			send_token(expr_tokens[i].mode, expr_tokens[i].operand, i == n - 1);
		expr_tokens.delete();
	endtask

	// Valid RPN: push while fewer than two values, otherwise mix pushes and
	// operators, and close once the length is reached with a single value left.
	task automatic build_wellformed(input int unsigned span);
		int unsigned depth;
		logic [2:0]  op;
		depth = 0;
		expr_tokens.delete();
		while (!(depth == 1 && expr_tokens.size() >= span)) begin
			if (depth >= 2 && (expr_tokens.size() >= span || depth >= 12 || $urandom_range(0, 1))) begin
				op = pick_operator();
				add_token(op, $urandom());
				depth = (op >= MODE_ADD && op <= MODE_DIV) ? depth - 1 : depth - 2;
			end else begin
				add_token(MODE_PUSH, pick_operand());
				depth++;
			end
		end
	endtask

	// Break a valid expression in one spot.
	task automatic mutate_expression();
		int unsigned idx;
		token_t      tok;
		idx = $urandom_range(0, expr_tokens.size() - 1);
		case ($urandom_range(0, 3))
			0: if (expr_tokens.size() > 1) expr_tokens.delete(idx);
			1: expr_tokens[idx].mode = 3'($urandom_range(0, 7));
			2: begin
				tok.mode    = MODE_PUSH;
				tok.operand = pick_operand();
				expr_tokens.insert(idx, tok);
			end
			default: begin
				tok.mode    = pick_operator();
				tok.operand = $urandom();
				expr_tokens.insert(idx, tok);
			end
		endcase
	endtask

	task automatic build_noise();
		expr_tokens.delete();
		repeat ($urandom_range(1, 6)) add_token(3'($urandom_range(0, 7)), $urandom());
	endtask

	// Fill the stack to its depth; then either spill one more push or fold it
	// back down to a single value.
	task automatic build_deep(input bit spill);
		expr_tokens.delete();
		repeat (STACK_DEPTH) add_token(MODE_PUSH, pick_operand());
		if (spill) begin
			add_token(MODE_PUSH, pick_operand());
			repeat ($urandom_range(0, 3)) add_token(3'($urandom_range(0, 7)), $urandom());
		end else begin
			repeat (STACK_DEPTH - 1) add_token(3'($urandom_range(MODE_ADD, MODE_DIV)), $urandom());
		end
	endtask

	task automatic run_directed();
		// most negative value: wrap on add, over minus one, and in a multiply
		add_token(MODE_PUSH, WORD_MAX);
		add_token(MODE_PUSH, 32'd1);
		add_token(MODE_ADD, $urandom());
		add_token(MODE_PUSH, '1);
		add_token(MODE_DIV, $urandom());
		add_token(MODE_PUSH, WORD_MAX);
		add_token(MODE_MUL, $urandom());
		run_expression();
		// truncation toward zero
		add_token(MODE_PUSH, -32'sd7);
		add_token(MODE_PUSH, 32'd2);
		add_token(MODE_DIV, $urandom());
		run_expression();
		// divide by zero, then a token that must be ignored
		add_token(MODE_PUSH, 32'd5);
		add_token(MODE_PUSH, '0);
		add_token(MODE_DIV, $urandom());
		add_token(MODE_PUSH, 32'd3);
		run_expression();
		// operator on an empty stack
		add_token(MODE_SUB, $urandom());
		run_expression();
		// other operator drops its operands; two values left at the end
		add_token(MODE_PUSH, 32'd4);
		add_token(MODE_PUSH, 32'd9);
		add_token(MODE_OTHER, $urandom());
		add_token(MODE_PUSH, 32'd1);
		add_token(MODE_PUSH, 32'd2);
		run_expression();
		// spare codes act as the other operator; nothing left at the end
		add_token(MODE_PUSH, 32'd1);
		add_token(MODE_PUSH, 32'd2);
		add_token(MODE_SPARE6, $urandom());
		add_token(MODE_PUSH, 32'd3);
		add_token(MODE_PUSH, 32'd4);
		add_token(MODE_SPARE7, $urandom());
		run_expression();
	endtask

	// Check each accepted result at the rising edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.match_result(m_tdata, m_tuser[2:0]);
	end

	// Result side: switch between randomly picked stall styles, and
	// hold off once for a long stretch while tokens keep coming.
	initial begin : result_sink
		int unsigned rx_cycle;
		int unsigned style;
		logic [7:0]  mask;
		logic        ready;
		rx_cycle = 0;
		style    = 0;
		mask     = 8'hff;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_hold_done && tokens_sent >= HOLD_AFTER_TOKENS) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				long_hold_done = 1'b1;
			end
			if (rx_cycle % 200 == 0) begin
				style = $urandom_range(0, 3);
				mask  = 8'($urandom()) | 8'h01;
			end
			case (style)
				0: ready = 1'b1;
				1: ready = ($urandom_range(0, 3) != 0);
				2: ready = mask[rx_cycle % 8];
				default: ready = ($urandom_range(0, 4) == 0);
			endcase
			m_tready <= ready;
			rx_cycle++;
		end
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned expr_idx;
		int unsigned roll;
		tracker        = new();
		tokens_sent    = 0;
		burst_left     = 0;
		long_hold_done = 1'b0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		expr_idx = 0;
		while (tokens_sent < ITEM_TARGET) begin
			roll = $urandom_range(0, 99);
			if (expr_idx == 5) build_deep(1'b1);
			else if (expr_idx == 30) build_deep(1'b0);
			else if (roll < 2) build_deep($urandom_range(0, 1));
			else if (roll < 72) build_wellformed(($urandom_range(0, 7) == 0)
				? $urandom_range(10, 30) : $urandom_range(1, 9));
			else if (roll < 87) begin
				build_wellformed($urandom_range(1, 12));
				mutate_expression();
			end else build_noise();
			run_expression();
			expr_idx++;
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// drain: wait for every owed result, then for any stray one
		while (tracker.pending_count() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.failures == 0 && tracker.pending_count() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
